@@ src/spw_pkg.sv @@
// shared types and status codes of the strip pulse peak window block
`default_nettype none

package spw_pkg;

    // width of one adc sample and of one twice-height value
    localparam int SAMPLE_W = 12;
    localparam int HEIGHT_W = 14;

    // result status codes
    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BIN0     = 2'd2,
        ST_PAST_END = 2'd3
    } spw_status_t;

    // pedestal samples and the four samples around the peak
    typedef struct packed {
        logic [SAMPLE_W-1:0] s0;
        logic [SAMPLE_W-1:0] s1;
        logic [SAMPLE_W-1:0] prior;
        logic [SAMPLE_W-1:0] peak;
        logic [SAMPLE_W-1:0] after;
        logic [SAMPLE_W-1:0] after_two;
    } spw_window_t;

endpackage

`default_nettype wire

@@ src/spw_tracker.sv @@
// per-sample peak tracking, window capture and closed-pulse snapshot register
`default_nettype none

module spw_tracker
    import spw_pkg::*;
#(
    parameter int MAX_SAMPLES = 8,
    localparam int CW = $clog2(MAX_SAMPLES + 1),
    localparam int BW = $clog2(MAX_SAMPLES)
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_take,
    input  wire logic [SAMPLE_W-1:0] adc_sample,
    input  wire logic                last_sample,
    input  wire logic                out_ready,
    output logic                     snap_valid,
    output logic [CW-1:0]            snap_count,
    output logic [BW-1:0]            snap_bin,
    output spw_window_t              snap_win
);

    localparam int EW = CW + 1;

    logic [CW-1:0]       count_reg, count_next, count_upd;
    logic [SAMPLE_W-1:0] max_value_reg, max_value_next;
    logic [BW-1:0]       max_bin_reg, max_bin_next, max_bin_upd;
    logic [SAMPLE_W-1:0] prev_reg, prev_next;
    spw_window_t         win_reg, win_next;
    logic                snap_valid_reg, snap_valid_next;
    logic [CW-1:0]       snap_count_reg;
    logic [BW-1:0]       snap_bin_reg;
    spw_window_t         snap_win_reg;

    logic          room;
    logic          new_max;
    logic [BW-1:0] idx;
    logic          snap_load;

    // store one sample, track the first maximum and catch the window samples
    always_comb
    begin
        room           = count_reg < CW'(MAX_SAMPLES);
        idx            = count_reg[BW-1:0];
        new_max        = (count_reg == '0) || (adc_sample > max_value_reg);
        count_upd      = count_reg;
        max_value_next = max_value_reg;
        max_bin_upd    = max_bin_reg;
        prev_next      = prev_reg;
        win_next       = win_reg;
        if (in_take && room)
        begin
            if (count_reg == CW'(0))
            begin
                win_next.s0 = adc_sample;
            end
            if (count_reg == CW'(1))
            begin
                win_next.s1 = adc_sample;
            end
            if (new_max)
            begin
                max_value_next  = adc_sample;
                max_bin_upd     = idx;
                win_next.prior  = prev_reg;
                win_next.peak   = adc_sample;
            end
            else if (EW'(count_reg) == EW'(max_bin_reg) + EW'(1))
            begin
                win_next.after = adc_sample;
            end
            else if (EW'(count_reg) == EW'(max_bin_reg) + EW'(2))
            begin
                win_next.after_two = adc_sample;
            end
            prev_next = adc_sample;
            count_upd = count_reg + CW'(1);
        end
        count_next   = count_upd;
        max_bin_next = max_bin_upd;
        if (in_take && last_sample)
        begin
            count_next     = '0;
            max_value_next = '0;
            max_bin_next   = '0;
        end
    end

    // snapshot slot fills on a last sample and empties toward the output
    always_comb
    begin
        snap_load       = in_take && last_sample;
        snap_valid_next = snap_valid_reg;
        if (snap_load)
        begin
            snap_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            snap_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            max_value_reg  <= '0;
            max_bin_reg    <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            max_value_reg  <= max_value_next;
            max_bin_reg    <= max_bin_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    // sample payload
    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        win_reg  <= win_next;
        if (snap_load)
        begin
            snap_count_reg <= count_upd;
            snap_bin_reg   <= max_bin_upd;
            snap_win_reg   <= win_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap_count = snap_count_reg;
    assign snap_bin   = snap_bin_reg;
    assign snap_win   = snap_win_reg;

endmodule

`default_nettype wire

@@ src/spw_result.sv @@
// status decision, pedestal-subtracted heights and output register
`default_nettype none

module spw_result
    import spw_pkg::*;
#(
    parameter int MAX_SAMPLES = 8,
    localparam int CW = $clog2(MAX_SAMPLES + 1),
    localparam int BW = $clog2(MAX_SAMPLES)
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       snap_valid,
    input  wire logic [CW-1:0]              snap_count,
    input  wire logic [BW-1:0]              snap_bin,
    input  wire spw_window_t                snap_win,
    input  wire logic                       out_stall,
    output logic                            out_ready,
    output logic                            out_valid,
    output logic [1:0]                      status,
    output logic [2:0]                      peak_bin,
    output logic signed [HEIGHT_W-1:0]      height_before,
    output logic signed [HEIGHT_W-1:0]      height_peak,
    output logic signed [HEIGHT_W-1:0]      height_after,
    output logic signed [HEIGHT_W-1:0]      height_after_two
);

    localparam int EW = CW + 1;

    logic                       out_valid_reg;
    spw_status_t                status_reg, status_next;
    logic [2:0]                 peak_bin_reg, peak_bin_next;
    logic signed [HEIGHT_W-1:0] hb_reg, hp_reg, ha_reg, ha2_reg;
    logic signed [HEIGHT_W-1:0] hb_next, hp_next, ha_next, ha2_next;
    logic [BW+2:0]              bin_ext;

    // twice the pedestal-subtracted value: 2*s - s0 - s1
    function automatic logic signed [HEIGHT_W-1:0] twice_height(
        input logic [SAMPLE_W-1:0] s,
        input logic [SAMPLE_W-1:0] s0,
        input logic [SAMPLE_W-1:0] s1
    );
        logic [HEIGHT_W-1:0] v;
        v = {1'b0, s, 1'b0} - {2'b00, s0} - {2'b00, s1};
        return $signed(v);
    endfunction

    // classify the pulse and form the heights
    always_comb
    begin
        bin_ext       = {3'b000, snap_bin};
        peak_bin_next = bin_ext[2:0];
        hb_next       = '0;
        hp_next       = '0;
        ha_next       = '0;
        ha2_next      = '0;
        if (snap_count == '0)
        begin
            status_next   = ST_EMPTY;
            peak_bin_next = '0;
        end
        else if (snap_bin == '0)
        begin
            status_next = ST_BIN0;
        end
        else if (EW'(snap_bin) + EW'(2) >= EW'(snap_count))
        begin
            status_next = ST_PAST_END;
        end
        else
        begin
            status_next = ST_FOUND;
            hb_next     = twice_height(snap_win.prior, snap_win.s0, snap_win.s1);
            hp_next     = twice_height(snap_win.peak, snap_win.s0, snap_win.s1);
            ha_next     = twice_height(snap_win.after, snap_win.s0, snap_win.s1);
            ha2_next    = twice_height(snap_win.after_two, snap_win.s0, snap_win.s1);
        end
    end

    assign out_ready = !out_valid_reg || !out_stall;

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= snap_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (out_ready && snap_valid)
        begin
            status_reg   <= status_next;
            peak_bin_reg <= peak_bin_next;
            hb_reg       <= hb_next;
            hp_reg       <= hp_next;
            ha_reg       <= ha_next;
            ha2_reg      <= ha2_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign peak_bin         = peak_bin_reg;
    assign height_before    = hb_reg;
    assign height_peak      = hp_reg;
    assign height_after     = ha_reg;
    assign height_after_two = ha2_reg;

endmodule

`default_nettype wire

@@ src/strip_pulse_peak_window_top.sv @@
// top level of the strip pulse peak window block
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | into      | in_valid / in_stall   | adc_sample, last_sample
//  out     | out of    | out_valid / out_stall | status, peak_bin, height_before ..
//          |           |                       | height_after_two
//
// one sample per cycle while in_stall is low; each needs one compare and a window capture
// a pulse's result passes the snapshot register and then the output register
// a snapshot register and the output register part the sample side from the result side
// in_stall rises only when a finished pulse waits in the snapshot and the output is stalled
// reset clears counters and valid flags at once; sample registers need no clearing
`default_nettype none

module strip_pulse_peak_window_top
    import spw_pkg::*;
#(
    parameter int MAX_SAMPLES = 8
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [SAMPLE_W-1:0]        adc_sample,
    input  wire logic                       last_sample,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [1:0]                      status,
    output logic [2:0]                      peak_bin,
    output logic signed [HEIGHT_W-1:0]      height_before,
    output logic signed [HEIGHT_W-1:0]      height_peak,
    output logic signed [HEIGHT_W-1:0]      height_after,
    output logic signed [HEIGHT_W-1:0]      height_after_two
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int BW = $clog2(MAX_SAMPLES);

    logic          in_take;
    logic          out_ready;
    logic          snap_valid;
    logic [CW-1:0] snap_count;
    logic [BW-1:0] snap_bin;
    spw_window_t   snap_win;

    // input handshake
    assign in_stall = snap_valid && !out_ready;
    assign in_take  = in_valid && !in_stall;

    spw_tracker #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_take     (in_take),
        .adc_sample  (adc_sample),
        .last_sample (last_sample),
        .out_ready   (out_ready),
        .snap_valid  (snap_valid),
        .snap_count  (snap_count),
        .snap_bin    (snap_bin),
        .snap_win    (snap_win)
    );

    spw_result #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_result (
        .clk              (clk),
        .rst_n            (rst_n),
        .snap_valid       (snap_valid),
        .snap_count       (snap_count),
        .snap_bin         (snap_bin),
        .snap_win         (snap_win),
        .out_stall        (out_stall),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .status           (status),
        .peak_bin         (peak_bin),
        .height_before    (height_before),
        .height_peak      (height_peak),
        .height_after     (height_after),
        .height_after_two (height_after_two)
    );

    // a last sample always leaves a pending pulse behind
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take && last_sample |=> snap_valid)
        else $error("last sample accepted without a pending pulse");

    // a pending pulse moves on when the output slot is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid && !out_valid |=> out_valid)
        else $error("pending pulse did not reach the output");

    // a found peak never sits in bin 0 unless the bin index wrapped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FOUND && MAX_SAMPLES <= 8 |-> peak_bin != 3'd0)
        else $error("found status with peak in bin 0");

    // heights are zero unless a peak was found
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_FOUND |->
            height_before == '0 && height_peak == '0 &&
            height_after == '0 && height_after_two == '0)
        else $error("nonzero height without a found peak");

endmodule

`default_nettype wire
